FILE: rtl/nbns_pkg.sv
// Shared types and constants of the NetBIOS name-query responder.
// No dependencies; the decoder, the core and the testbench take names from here by scope.
package nbns_pkg;

  localparam int unsigned NameChars = 16;
  localparam int unsigned ReqLen    = 50;
  localparam int unsigned RespLen   = 62;
  localparam int unsigned EncFirst  = 13;
  localparam int unsigned EncLast   = 45;

  localparam int unsigned CntW = $clog2(NameChars + 1);
  localparam int unsigned PosW = $clog2(ReqLen + 1);
  localparam int unsigned IdxW = $clog2(RespLen);

  localparam logic [7:0]  RespFlagsHi = 8'h85;
  localparam logic [7:0]  RespDataLen = 8'd6;
  localparam logic [31:0] TtlReset    = 32'd10;

  typedef enum logic [7:0] {
    REG_NAME_FIRST  = 8'd0,
    REG_NAME_SECOND = 8'd1,
    REG_OWN_ADDR    = 8'd2,
    REG_LIFETIME    = 8'd3
  } reg_idx_e;

  typedef struct packed {
    logic [3:0]      high;
    logic            phase;
    logic [CntW-1:0] cnt;
    logic            fin;
    logic            ended;
    logic            mis;
    logic            ill;
  } dec_t;

endpackage

FILE: rtl/nbns_if.sv
// Handshake channel interfaces of the responder: receive, transmit, register write.
// Depends on nothing.
interface nbns_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_last;
  modport source (output valid, rx_byte, rx_last, input ready);
  modport sink   (input valid, rx_byte, rx_last, output ready);
endinterface

interface nbns_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_last;
  modport source (output valid, tx_byte, tx_last, input ready);
  modport sink   (input valid, tx_byte, tx_last, output ready);
endinterface

interface nbns_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/nbns_decode.sv
// First-level name decoder and name compare: next decode state for one request byte.
// Depends on nbns_pkg.
module nbns_decode (
  input  nbns_pkg::dec_t                 state_i,
  input  logic [nbns_pkg::PosW-1:0]      pos_i,
  input  logic [7:0]                     byte_i,
  input  logic [8*nbns_pkg::NameChars-1:0] name_i,
  output nbns_pkg::dec_t                 state_o
);

  localparam logic [7:0] ChA   = 8'h41;
  localparam logic [7:0] ChZ   = 8'h5A;
  localparam logic [7:0] ChDot = 8'h2E;
  localparam logic [7:0] ChSp  = 8'h20;
  localparam logic [7:0] ChNul = 8'h00;
  localparam int unsigned N    = nbns_pkg::NameChars;

  logic [7:0] name_chr [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      name_chr[i] = name_i[8*(N-1-i) +: 8];
    end
  end

  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= ChA && c <= ChZ) ? c + 8'd32 : c;
  endfunction

  always_comb begin
    nbns_pkg::dec_t s;
    logic [7:0] d;
    logic [7:0] ch;
    logic [7:0] want;
    logic       letter;
    s      = state_i;
    d      = byte_i - ChA;
    letter = (byte_i >= ChA) && (byte_i <= ChZ);
    ch     = {s.high[3:1], s.high[0] | d[4], d[3:0]};
    want   = name_chr[s.cnt[$clog2(N)-1:0]];
    if (pos_i >= nbns_pkg::PosW'(nbns_pkg::EncFirst) &&
        pos_i <= nbns_pkg::PosW'(nbns_pkg::EncLast) && !s.ended && !s.ill) begin
      if (!s.phase) begin
        if (byte_i == ChNul || byte_i == ChDot) begin
          s.ended = 1'b1;
          if (!s.fin) begin
            s.fin = 1'b1;
            if (s.cnt < nbns_pkg::CntW'(N) && want != ChNul) s.mis = 1'b1;
          end
        end else if (!letter) begin
          s.ill = 1'b1;
        end else begin
          s.high  = d[3:0];
          s.phase = 1'b1;
        end
      end else if (!letter) begin
        s.ill = 1'b1;
      end else begin
        s.phase = 1'b0;
        if (s.cnt < nbns_pkg::CntW'(N) && !s.fin) begin
          if (ch == ChNul || ch == ChSp) begin
            s.fin = 1'b1;
            if (want != ChNul) s.mis = 1'b1;
          end else begin
            s.cnt = s.cnt + 1'b1;
            if (want == ChNul || fold(ch) != fold(want)) s.mis = 1'b1;
          end
        end
      end
      want = name_chr[s.cnt[$clog2(N)-1:0]];
      if (pos_i == nbns_pkg::PosW'(nbns_pkg::EncLast) && !s.ended && !s.ill) begin
        if (s.phase) begin
          s.ill = 1'b1;
        end else begin
          s.ended = 1'b1;
          if (!s.fin) begin
            s.fin = 1'b1;
            if (s.cnt < nbns_pkg::CntW'(N) && want != ChNul) s.mis = 1'b1;
          end
        end
      end
    end
    state_o = s;
  end

endmodule

FILE: rtl/netbios_name_query_responder_core.sv
// Top level of the NetBIOS name-query responder: request store, decode state, reply sequencer.
// Depends on nbns_pkg, nbns_if (channel interfaces) and nbns_decode.
//
//  channel | dir | payload              | role
//  rx_i    | in  | rx_byte[8], rx_last  | request payload, one byte per transaction
//  tx_o    | out | tx_byte[8], tx_last  | response payload, 62 transactions per reply
//  cfg_i   | in  | index[8], data[64]   | register write
//
// Request bytes stream back to back while no reply is pending.
// A reply emits 62 bytes, one per cycle while tx_o takes them, fetched through the store's
// single read port into a read register ahead of the output register.
// rx_i is held off from the final byte of a replying request until the last reply byte
// has left. tx_o stalls freeze the read pipeline in place. No clearing pass after reset.
module netbios_name_query_responder_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  nbns_rx_if.sink      rx_i,
  nbns_tx_if.source    tx_o,
  nbns_cfg_if.sink     cfg_i
);

  localparam int unsigned PosW = nbns_pkg::PosW;
  localparam int unsigned IdxW = nbns_pkg::IdxW;

  logic [63:0] name0_q, name1_q;
  logic [31:0] addr_q, ttl_q;

  logic [7:0] mem [nbns_pkg::ReqLen];
  logic [7:0] rd_q;

  logic [PosW-1:0] pos_q, pos_d;
  logic            hdr_bad_q, hdr_bad_d;
  nbns_pkg::dec_t  dec_q, dec_d;

  logic            iss_q;
  logic [IdxW-1:0] k_q;
  logic            a_vld_q;
  logic [IdxW-1:0] a_idx_q;
  logic            b_vld_q;
  logic [7:0]      b_byte_q, b_byte_d;
  logic            b_last_q;

  logic rx_acc, reply, advance, busy, in_store;

  assign busy     = iss_q | a_vld_q | b_vld_q;
  assign rx_i.ready = !busy;
  assign rx_acc   = rx_i.valid && rx_i.ready;
  assign advance  = !b_vld_q || tx_o.ready;
  assign in_store = pos_q < PosW'(nbns_pkg::ReqLen);
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name0_q <= '0;
      name1_q <= '0;
      addr_q  <= '0;
      ttl_q   <= nbns_pkg::TtlReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        nbns_pkg::REG_NAME_FIRST:  name0_q <= cfg_i.data;
        nbns_pkg::REG_NAME_SECOND: name1_q <= cfg_i.data;
        nbns_pkg::REG_OWN_ADDR:    addr_q  <= cfg_i.data[31:0];
        nbns_pkg::REG_LIFETIME:    ttl_q   <= cfg_i.data[31:0];
        default: ;
      endcase
    end
  end

  nbns_decode u_decode (
    .state_i (dec_q),
    .pos_i   (pos_q),
    .byte_i  (rx_i.rx_byte),
    .name_i  ({name0_q, name1_q}),
    .state_o (dec_d)
  );

  always_comb begin
    hdr_bad_d = hdr_bad_q;
    case (pos_q)
      PosW'(2): if (rx_i.rx_byte[7:3] != '0) hdr_bad_d = 1'b1;
      PosW'(4): if (rx_i.rx_byte != 8'd0) hdr_bad_d = 1'b1;
      PosW'(5): if (rx_i.rx_byte != 8'd1) hdr_bad_d = 1'b1;
      default: ;
    endcase
    pos_d = in_store ? pos_q + 1'b1 : pos_q;
  end

  assign reply = rx_i.rx_last && (pos_d == PosW'(nbns_pkg::ReqLen)) && !hdr_bad_d &&
                 !dec_d.ill && !dec_d.mis && dec_d.fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      hdr_bad_q <= 1'b0;
      dec_q     <= '0;
    end else if (rx_acc) begin
      if (rx_i.rx_last) begin
        pos_q     <= '0;
        hdr_bad_q <= 1'b0;
        dec_q     <= '0;
      end else begin
        pos_q     <= pos_d;
        hdr_bad_q <= hdr_bad_d;
        if (in_store) dec_q <= dec_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_acc && in_store) mem[pos_q] <= rx_i.rx_byte;
    if (advance && iss_q && k_q < IdxW'(nbns_pkg::ReqLen)) rd_q <= mem[k_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q   <= 1'b0;
      k_q     <= '0;
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (rx_acc && reply) begin
        iss_q <= 1'b1;
        k_q   <= '0;
      end else if (advance && iss_q) begin
        k_q <= k_q + 1'b1;
        if (k_q == IdxW'(nbns_pkg::RespLen - 1)) iss_q <= 1'b0;
      end
      if (advance) begin
        a_vld_q <= iss_q;
        b_vld_q <= a_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      a_idx_q  <= k_q;
      b_byte_q <= b_byte_d;
      b_last_q <= a_idx_q == IdxW'(nbns_pkg::RespLen - 1);
    end
  end

  always_comb begin
    case (a_idx_q) inside
      [0:1], [12:49]: b_byte_d = rd_q;
      2:              b_byte_d = nbns_pkg::RespFlagsHi;
      7:              b_byte_d = 8'd1;
      50:             b_byte_d = ttl_q[31:24];
      51:             b_byte_d = ttl_q[23:16];
      52:             b_byte_d = ttl_q[15:8];
      53:             b_byte_d = ttl_q[7:0];
      55:             b_byte_d = nbns_pkg::RespDataLen;
      58:             b_byte_d = addr_q[31:24];
      59:             b_byte_d = addr_q[23:16];
      60:             b_byte_d = addr_q[15:8];
      61:             b_byte_d = addr_q[7:0];
      default:        b_byte_d = 8'd0;
    endcase
  end

  assign tx_o.valid   = b_vld_q;
  assign tx_o.tx_byte = b_byte_q;
  assign tx_o.tx_last = b_last_q;

  a_no_rx_while_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_i.ready |-> !tx_o.valid && !iss_q)
    else $error("request accepted while a reply is pending");

  a_reply_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_acc && reply |=> iss_q && k_q == '0 && !a_vld_q && !b_vld_q)
    else $error("reply sequencer did not start cleanly");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_o.valid && tx_o.ready && tx_o.tx_last |=> rx_i.ready)
    else $error("responder not idle after final reply byte");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_vld_q |-> a_idx_q <= IdxW'(nbns_pkg::RespLen - 1))
    else $error("reply index beyond response length");

endmodule

FILE: verif/netbios_name_query_responder_core_test.sv
// Self-checking testbench for netbios_name_query_responder_core: streams name-query payloads
// with random gaps and stalls, predicts every reply byte and compares it on the transmit side.
// Depends on nbns_pkg and the channel interfaces in nbns_if.
`timescale 1ns / 1ps

module netbios_name_query_responder_core_test;

  typedef logic [7:0] byte_queue_t [$];

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_byte_t;

  localparam int unsigned HalfPeriod  = 5;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned MaxReports  = 10;

  localparam logic [7:0]  LetterA     = 8'h41;
  localparam logic [7:0]  LetterZ     = 8'h5A;
  localparam logic [7:0]  CaseBit     = 8'h20;
  localparam logic [7:0]  CharSpace   = 8'h20;
  localparam logic [7:0]  CharDot     = 8'h2E;
  localparam logic [7:0]  CharNul     = 8'h00;
  localparam logic [7:0]  EncodedLen  = 8'h20;
  localparam logic [7:0]  AnswerCount = 8'd1;
  localparam logic [15:0] OpcodeMask  = 16'h7800;
  localparam logic [15:0] ResponseBit = 16'h8000;
  localparam logic [15:0] StdFlags    = 16'h0110;
  localparam logic [15:0] OneQuestion = 16'd1;

  localparam int unsigned FlagsAt       = 2;
  localparam int unsigned AnswerCountAt = 7;
  localparam int unsigned NameAt        = 12;
  localparam int unsigned LifetimeAt    = 50;
  localparam int unsigned DataLenAt     = 55;
  localparam int unsigned AddressAt     = 58;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  nbns_rx_if  rx_ch ();
  nbns_tx_if  tx_ch ();
  nbns_cfg_if cfg_ch ();

  netbios_name_query_responder_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_ch),
    .tx_o   (tx_ch),
    .cfg_i  (cfg_ch)
  );

  always #HalfPeriod clk_i = ~clk_i;

  logic [63:0] cfg_name_first;
  logic [63:0] cfg_name_second;
  logic [31:0] cfg_address;
  logic [31:0] cfg_lifetime;

  logic [7:0]  req_store [nbns_pkg::ReqLen];
  int unsigned req_pos;
  logic [7:0]  hi_part;
  bit          in_pair;
  int unsigned chars_seen;
  bit          name_done;
  bit          enc_done;
  bit          name_bad;
  bit          enc_bad;

  reply_byte_t reply_due [$];
  reply_byte_t reply_head;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned rx_calm = 0;
  int unsigned tx_calm = 0;
  byte_queue_t active_name;

  function automatic logic [7:0] wanted_char(int unsigned i);
    if (i < 8) return cfg_name_first[63 - 8 * i -: 8];
    if (i < nbns_pkg::NameChars) return cfg_name_second[63 - 8 * (i - 8) -: 8];
    return CharNul;
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= LetterA && c <= LetterZ) ? (c | CaseBit) : c;
  endfunction

  function automatic void close_name();
    if (name_done) return;
    name_done = 1'b1;
    if (chars_seen < nbns_pkg::NameChars && wanted_char(chars_seen) != CharNul)
      name_bad = 1'b1;
  endfunction

  function automatic void take_char(logic [7:0] ch);
    logic [7:0] want;
    if (chars_seen >= nbns_pkg::NameChars || name_done) return;
    if (ch == CharNul || ch == CharSpace) begin
      close_name();
      return;
    end
    want = wanted_char(chars_seen);
    chars_seen++;
    if (want == CharNul || fold_case(ch) != fold_case(want)) name_bad = 1'b1;
  endfunction

  function automatic void decode_letter(logic [7:0] c);
    logic [7:0] nib;
    if (enc_done || enc_bad) return;
    nib = c - LetterA;
    if (!in_pair) begin
      if (c == CharNul || c == CharDot) begin
        enc_done = 1'b1;
        close_name();
      end else if (c < LetterA || c > LetterZ) begin
        enc_bad = 1'b1;
      end else begin
        hi_part = nib << 4;
        in_pair = 1'b1;
      end
    end else if (c < LetterA || c > LetterZ) begin
      enc_bad = 1'b1;
    end else begin
      in_pair = 1'b0;
      take_char(hi_part | nib);
    end
  endfunction

  function automatic void clear_request();
    req_pos    = 0;
    hi_part    = 8'h00;
    in_pair    = 1'b0;
    chars_seen = 0;
    name_done  = 1'b0;
    enc_done   = 1'b0;
    name_bad   = 1'b0;
    enc_bad    = 1'b0;
  endfunction

  function automatic void reset_model();
    cfg_name_first  = '0;
    cfg_name_second = '0;
    cfg_address     = '0;
    cfg_lifetime    = nbns_pkg::TtlReset;
    foreach (req_store[i]) req_store[i] = 8'h00;
    clear_request();
  endfunction

  function automatic void queue_reply();
    reply_byte_t r;
    for (int k = 0; k < nbns_pkg::RespLen; k++) begin
      r.data = 8'h00;
      if (k < FlagsAt || (k >= NameAt && k < nbns_pkg::ReqLen)) r.data = req_store[k];
      else if (k == FlagsAt) r.data = nbns_pkg::RespFlagsHi;
      else if (k == AnswerCountAt) r.data = AnswerCount;
      else if (k >= LifetimeAt && k < LifetimeAt + 4)
        r.data = cfg_lifetime[31 - 8 * (k - LifetimeAt) -: 8];
      else if (k == DataLenAt) r.data = nbns_pkg::RespDataLen;
      else if (k >= AddressAt) r.data = cfg_address[31 - 8 * (k - AddressAt) -: 8];
      r.last = (k == nbns_pkg::RespLen - 1);
      reply_due.push_back(r);
    end
  endfunction

  function automatic void absorb_request_byte(logic [7:0] b, logic last);
    logic [15:0] flags;
    logic [15:0] questions;
    bit          answer;
    if (req_pos < nbns_pkg::ReqLen) begin
      req_store[req_pos] = b;
      if (req_pos >= nbns_pkg::EncFirst && req_pos <= nbns_pkg::EncLast) begin
        decode_letter(b);
        if (req_pos == nbns_pkg::EncLast && !enc_done && !enc_bad) begin
          if (in_pair) begin
            enc_bad = 1'b1;
          end else begin
            enc_done = 1'b1;
            close_name();
          end
        end
      end
      req_pos++;
    end
    if (!last) return;
    flags     = {req_store[2], req_store[3]};
    questions = {req_store[4], req_store[5]};
    answer = req_pos >= nbns_pkg::ReqLen && (flags & OpcodeMask) == 16'h0 &&
             (flags & ResponseBit) == 16'h0 && questions == OneQuestion &&
             !enc_bad && !name_bad && name_done;
    clear_request();
    if (answer) queue_reply();
  endfunction

  function automatic int unsigned draw_gap(inout int unsigned calm_left);
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  function automatic byte_queue_t random_name(int unsigned len);
    byte_queue_t nm;
    logic [7:0]  c;
    repeat (len) begin
      if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(1, 255));
      else c = 8'($urandom_range(33, 126));
      if (c == CharSpace) c = LetterZ;
      nm.push_back(c);
    end
    return nm;
  endfunction

  function automatic byte_queue_t make_query(byte_queue_t chars, logic [7:0] stop,
                                             logic [15:0] flags, logic [15:0] questions,
                                             int unsigned tail);
    byte_queue_t pkt;
    logic [7:0]  c;
    pkt.push_back(8'($urandom));
    pkt.push_back(8'($urandom));
    pkt.push_back(flags[15:8]);
    pkt.push_back(flags[7:0]);
    pkt.push_back(questions[15:8]);
    pkt.push_back(questions[7:0]);
    repeat (6) pkt.push_back(8'($urandom));
    pkt.push_back(EncodedLen);
    foreach (chars[i]) begin
      c = chars[i];
      if ((c & ~CaseBit) >= LetterA && (c & ~CaseBit) <= LetterZ && $urandom_range(0, 1))
        c = c ^ CaseBit;
      pkt.push_back(LetterA + c[7:4]);
      pkt.push_back(LetterA + c[3:0]);
    end
    if (pkt.size() <= nbns_pkg::EncLast) pkt.push_back(stop);
    while (pkt.size() <= nbns_pkg::EncLast) pkt.push_back(8'($urandom));
    repeat (4 + tail) pkt.push_back(8'($urandom));
    return pkt;
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = draw_gap(rx_calm);
    if (gap != 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    rx_ch.rx_last <= last;
    do @(posedge clk_i); while (!rx_ch.ready);
    absorb_request_byte(b, last);
  endtask

  task automatic send_packet(byte_queue_t pkt);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic wait_idle();
    rx_ch.valid <= 1'b0;
    while (reply_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] index, logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (index)
      nbns_pkg::REG_NAME_FIRST:  cfg_name_first  = value;
      nbns_pkg::REG_NAME_SECOND: cfg_name_second = value;
      nbns_pkg::REG_OWN_ADDR:    cfg_address     = value[31:0];
      nbns_pkg::REG_LIFETIME:    cfg_lifetime    = value[31:0];
      default: ;
    endcase
  endtask

  task automatic configure(byte_queue_t nm, logic [31:0] address, logic [31:0] lifetime,
                           bit stray);
    logic [127:0] packed_name;
    packed_name = '0;
    for (int i = 0; i < nm.size() && i < nbns_pkg::NameChars; i++)
      packed_name[127 - 8 * i -: 8] = nm[i];
    wait_idle();
    if (stray)
      write_reg(8'($urandom_range(nbns_pkg::REG_LIFETIME + 1, 255)), {$urandom, $urandom});
    write_reg(nbns_pkg::REG_NAME_FIRST, packed_name[127:64]);
    write_reg(nbns_pkg::REG_NAME_SECOND, packed_name[63:0]);
    write_reg(nbns_pkg::REG_OWN_ADDR, {32'($urandom), address});
    write_reg(nbns_pkg::REG_LIFETIME, {32'($urandom), lifetime});
    cfg_ch.valid <= 1'b0;
    active_name = nm;
  endtask

  task automatic test_reset_defaults();
    byte_queue_t none;
    send_packet(make_query(none, CharDot, StdFlags, OneQuestion, 0));
  endtask

  task automatic test_register_extremes();
    byte_queue_t full;
    repeat (nbns_pkg::NameChars) full.push_back(8'hFF);
    configure(full, '1, '1, 1'b1);
    send_packet(make_query(full, CharNul, StdFlags, OneQuestion, 0));
  endtask

  task automatic test_name_decoding();
    byte_queue_t nm;
    byte_queue_t q;
    nm    = random_name(6);
    nm[0] = "k";
    nm[1] = "Q";
    configure(nm, $urandom, $urandom, 1'b0);
    q = nm;
    while (q.size() < nbns_pkg::NameChars) q.push_back(CharSpace);
    send_packet(make_query(q, CharNul, StdFlags, OneQuestion, 0));
    q = make_query(nm, CharNul, StdFlags, OneQuestion, 0);
    q[nbns_pkg::EncFirst + 1] = CharNul;
    send_packet(q);
  endtask

  task automatic test_header_checks();
    logic [15:0] flags;
    logic [15:0] questions;
    flags     = StdFlags;
    questions = OneQuestion;
    case ($urandom_range(0, 2))
      0: flags = StdFlags | OpcodeMask;
      1: flags = StdFlags | ResponseBit;
      default: questions = 16'h0002;
    endcase
    send_packet(make_query(active_name, CharNul, flags, questions, 0));
  endtask

  task automatic test_packet_length();
    byte_queue_t q;
    q = make_query(active_name, CharNul, StdFlags, OneQuestion, 0);
    void'(q.pop_back());
    send_packet(q);
    send_packet(make_query(active_name, CharDot, StdFlags, OneQuestion, 2));
  endtask

  initial begin
    tx_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      int unsigned gap;
      gap = draw_gap(tx_calm);
      if (gap != 0) begin
        tx_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      tx_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!tx_ch.valid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && tx_ch.valid && tx_ch.ready) begin
      if (reply_due.size() == 0) begin
        if (mismatches < MaxReports)
          $display("unexpected reply byte: actual byte %h last %b", tx_ch.tx_byte,
                   tx_ch.tx_last);
        mismatches++;
      end else begin
        reply_head = reply_due.pop_front();
        if (tx_ch.tx_byte !== reply_head.data || tx_ch.tx_last !== reply_head.last) begin
          if (mismatches < MaxReports)
            $display("reply byte mismatch: expected byte %h last %b, actual byte %h last %b",
                     reply_head.data, reply_head.last, tx_ch.tx_byte, tx_ch.tx_last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    rx_ch.rx_last <= 1'b0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= 8'h00;
    cfg_ch.data   <= 64'h0;
    reset_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_register_extremes();
    test_name_decoding();
    test_header_checks();
    test_packet_length();
    wait_idle();
    if (mismatches == 0 && reply_due.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
